// File: hdl/recs_pkg.sv
// recs_pkg: widths and fixed-point constants for the ray/ellipsoid chord sum.
// No dependencies; imported by ray_ellipsoid_chord_sum, recs_checker and tb_top.

package recs_pkg;

  localparam int COORD_W         = 24;
  localparam int DENS_W          = 16;
  localparam int SUM_W           = 32;
  localparam int COORD_FRAC_BITS = 16;

  localparam int MUL_W   = 26;                 // signed multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CHUNK_W = 25;                 // low chunk of a wide operand
  localparam int MAG_W   = 2 * COORD_W;        // |a|, |b|, |c|
  localparam int D_W     = 2 * MAG_W;          // discriminant
  localparam int ROOT_W  = MAG_W;              // floor(sqrt(d))
  localparam int ACC_W   = D_W + 2;            // signed accumulator
  localparam int SUB_W   = ROOT_W + 4;         // shared subtractor
  localparam int P_W     = ROOT_W + DENS_W;    // sqrt(d) * density
  localparam int SCALE_SH = 9;                 // 2 * Q8.8 -> Q16.16
  localparam int TOP_LSB  = SUM_W - SCALE_SH;  // p >> TOP_LSB = (p << 9) >> 32
  localparam int TOP_W    = P_W - TOP_LSB;

  localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << (2 * COORD_FRAC_BITS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;

endpackage

// File: hdl/ray_ellipsoid_chord_sum.sv
// ray_ellipsoid_chord_sum: top level, multi-cycle sequencer around one shared
// 26x26 multiplier and one shared 52-bit subtractor. Uses recs_pkg.
//
// Each request is one ray/ellipsoid pair; the block adds 2*sqrt(d)/a times
// density to a saturating Q16.16 sum and returns the sum on a last_shape
// request. One request at a time: the block is not ready again until a pair
// is through. A miss skips the square-root, density multiply and divide steps,
// and a clipping term skips the divide steps. The 19 multiply steps run through
// the single multiplier with a product register ahead of the accumulator; the
// 48 square-root steps and the 32 divide steps retire one bit per cycle through
// the shared subtractor. The result sits in an output register, so the next
// request is taken while it waits; a last_shape request stalls only in its
// final accumulate step if the previous result is still unread.

module ray_ellipsoid_chord_sum
  import recs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  coord_t            in_origin_x,
  input  coord_t            in_origin_y,
  input  coord_t            in_origin_z,
  input  coord_t            in_dir_x,
  input  coord_t            in_dir_y,
  input  coord_t            in_dir_z,
  input  logic [DENS_W-1:0] in_density,
  input  logic              in_last_shape,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SUM_W-1:0]  out_line_integral,
  output logic              out_saturated
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DCHK = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;

  localparam logic [2:0] GRP_A = 3'd0;  // D.D
  localparam logic [2:0] GRP_B = 3'd1;  // D.O
  localparam logic [2:0] GRP_C = 3'd2;  // O.O - 1
  localparam logic [2:0] GRP_D = 3'd3;  // b*b - a*c
  localparam logic [2:0] GRP_E = 3'd4;  // sqrt(d) * density

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_1C = 2'd1;
  localparam logic [1:0] SH_2C = 2'd2;

  logic [2:0]              state_r, state_nxt;
  logic [2:0]              grp_r, grp_nxt;
  logic [3:0]              k_r, k_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  coord_t                  ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic [DENS_W-1:0]       den_r;
  logic                    last_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                    pv_r, pv_nxt;
  logic [1:0]              psh_r, psh_nxt;
  logic                    pneg_r, pneg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [MAG_W-1:0]        a_r, a_nxt, bm_r, bm_nxt, cm_r, cm_nxt;
  logic                    cneg_r, cneg_nxt;
  logic [D_W-1:0]          wk_r, wk_nxt;
  logic [SUB_W-1:0]        rem_r, rem_nxt;
  logic [ROOT_W-1:0]       root_r, root_nxt;
  logic                    zero_r, zero_nxt;
  logic                    tsat_r, tsat_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic                    clip_r, clip_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]        out_sum_r, out_sum_nxt;
  logic                    out_sat_r, out_sat_nxt;

  // multiplier operand select
  mul_op_t                 mul_x, mul_y;
  logic [1:0]              sh_sel;
  logic                    neg_sel;
  logic [3:0]              n_steps;
  mul_op_t                 b_lo, b_hi, a_lo, a_hi, c_lo, c_hi, s_lo, s_hi, den_op;

  // accumulate path
  logic signed [ACC_W-1:0] pext, pshf, acc_add, acc_abs;

  // shared subtractor
  logic [SUB_W-1:0]        sub_x, sub_y;
  logic [SUB_W:0]          sub_d;
  logic                    sub_ge;

  // final add
  logic [SUM_W-1:0]        term, new_sum;
  logic [SUM_W:0]          sum_ext;
  logic                    new_clip;

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_line_integral = out_sum_r;
  assign out_saturated     = out_sat_r;

  assign b_lo   = {1'b0, bm_r[CHUNK_W-1:0]};
  assign b_hi   = {{(MUL_W-MAG_W+CHUNK_W){1'b0}}, bm_r[MAG_W-1:CHUNK_W]};
  assign a_lo   = {1'b0, a_r[CHUNK_W-1:0]};
  assign a_hi   = {{(MUL_W-MAG_W+CHUNK_W){1'b0}}, a_r[MAG_W-1:CHUNK_W]};
  assign c_lo   = {1'b0, cm_r[CHUNK_W-1:0]};
  assign c_hi   = {{(MUL_W-MAG_W+CHUNK_W){1'b0}}, cm_r[MAG_W-1:CHUNK_W]};
  assign s_lo   = {1'b0, root_r[CHUNK_W-1:0]};
  assign s_hi   = {{(MUL_W-ROOT_W+CHUNK_W){1'b0}}, root_r[ROOT_W-1:CHUNK_W]};
  assign den_op = {{(MUL_W-DENS_W){1'b0}}, den_r};

  always_comb begin
    mul_x   = '0;
    mul_y   = '0;
    sh_sel  = SH_0;
    neg_sel = 1'b0;
    n_steps = 4'd3;
    unique case (grp_r)
      GRP_A: begin
        unique case (k_r[1:0])
          2'd0:    begin mul_x = MUL_W'(dx_r); mul_y = MUL_W'(dx_r); end
          2'd1:    begin mul_x = MUL_W'(dy_r); mul_y = MUL_W'(dy_r); end
          default: begin mul_x = MUL_W'(dz_r); mul_y = MUL_W'(dz_r); end
        endcase
      end
      GRP_B: begin
        unique case (k_r[1:0])
          2'd0:    begin mul_x = MUL_W'(dx_r); mul_y = MUL_W'(ox_r); end
          2'd1:    begin mul_x = MUL_W'(dy_r); mul_y = MUL_W'(oy_r); end
          default: begin mul_x = MUL_W'(dz_r); mul_y = MUL_W'(oz_r); end
        endcase
      end
      GRP_C: begin
        unique case (k_r[1:0])
          2'd0:    begin mul_x = MUL_W'(ox_r); mul_y = MUL_W'(ox_r); end
          2'd1:    begin mul_x = MUL_W'(oy_r); mul_y = MUL_W'(oy_r); end
          default: begin mul_x = MUL_W'(oz_r); mul_y = MUL_W'(oz_r); end
        endcase
      end
      GRP_D: begin
        n_steps = 4'd8;
        unique case (k_r[2:0])
          3'd0: begin mul_x = b_lo; mul_y = b_lo; sh_sel = SH_0;  end
          3'd1: begin mul_x = b_lo; mul_y = b_hi; sh_sel = SH_1C; end
          3'd2: begin mul_x = b_hi; mul_y = b_lo; sh_sel = SH_1C; end
          3'd3: begin mul_x = b_hi; mul_y = b_hi; sh_sel = SH_2C; end
          3'd4: begin mul_x = a_lo; mul_y = c_lo; sh_sel = SH_0;  neg_sel = !cneg_r; end
          3'd5: begin mul_x = a_lo; mul_y = c_hi; sh_sel = SH_1C; neg_sel = !cneg_r; end
          3'd6: begin mul_x = a_hi; mul_y = c_lo; sh_sel = SH_1C; neg_sel = !cneg_r; end
          default: begin
            mul_x = a_hi; mul_y = c_hi; sh_sel = SH_2C; neg_sel = !cneg_r;
          end
        endcase
      end
      default: begin
        n_steps = 4'd2;
        if (k_r[0]) begin
          mul_x = s_hi; mul_y = den_op; sh_sel = SH_1C;
        end else begin
          mul_x = s_lo; mul_y = den_op; sh_sel = SH_0;
        end
      end
    endcase
  end

  always_comb begin
    pext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    unique case (psh_r)
      SH_1C:   pshf = pext <<< CHUNK_W;
      SH_2C:   pshf = pext <<< (2 * CHUNK_W);
      default: pshf = pext;
    endcase
    acc_add = pneg_r ? (acc_r - pshf) : (acc_r + pshf);
    acc_abs = acc_r[ACC_W-1] ? -acc_r : acc_r;
  end

  always_comb begin
    unique case (state_r)
      ST_SQRT: begin
        sub_x = {rem_r[SUB_W-3:0], wk_r[D_W-1 -: 2]};
        sub_y = {{(SUB_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
      end
      ST_DCHK: begin
        sub_x = rem_r;
        sub_y = {{(SUB_W-MAG_W){1'b0}}, a_r};
      end
      ST_DIV: begin
        sub_x = {rem_r[SUB_W-2:0], wk_r[D_W-1]};
        sub_y = {{(SUB_W-MAG_W){1'b0}}, a_r};
      end
      default: begin
        sub_x = '0;
        sub_y = '0;
      end
    endcase
    sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
    sub_ge = !sub_d[SUB_W];
  end

  always_comb begin
    priority if (zero_r) begin
      term = '0;
    end else if (tsat_r) begin
      term = '1;
    end else begin
      term = root_r[SUM_W-1:0];
    end
    sum_ext  = {1'b0, sum_r} + {1'b0, term};
    new_sum  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    new_clip = clip_r | tsat_r | sum_ext[SUM_W];
  end

  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    pv_nxt        = pv_r;
    psh_nxt       = psh_r;
    pneg_nxt      = pneg_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    bm_nxt        = bm_r;
    cm_nxt        = cm_r;
    cneg_nxt      = cneg_r;
    wk_nxt        = wk_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    zero_nxt      = zero_r;
    tsat_nxt      = tsat_r;
    sum_nxt       = sum_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          grp_nxt   = GRP_A;
          k_nxt     = '0;
          pv_nxt    = 1'b0;
          acc_nxt   = '0;
          zero_nxt  = 1'b0;
          tsat_nxt  = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        pv_nxt = 1'b0;
        if (pv_r) begin
          acc_nxt = acc_add;
        end
        if (k_r < n_steps) begin
          prod_nxt = mul_x * mul_y;
          psh_nxt  = sh_sel;
          pneg_nxt = neg_sel;
          pv_nxt   = 1'b1;
          k_nxt    = k_r + 4'd1;
        end else if (!pv_r) begin
          k_nxt   = '0;
          acc_nxt = '0;
          unique case (grp_r)
            GRP_A: begin
              a_nxt   = acc_r[MAG_W-1:0];
              grp_nxt = GRP_B;
            end
            GRP_B: begin
              bm_nxt  = acc_abs[MAG_W-1:0];
              acc_nxt = '0 - ONE_Q;
              grp_nxt = GRP_C;
            end
            GRP_C: begin
              cm_nxt   = acc_abs[MAG_W-1:0];
              cneg_nxt = acc_r[ACC_W-1];
              grp_nxt  = GRP_D;
            end
            GRP_D: begin
              if (acc_r[ACC_W-1] || (acc_r == '0)) begin
                zero_nxt  = 1'b1;
                state_nxt = ST_ACC;
              end else begin
                wk_nxt    = acc_r[D_W-1:0];
                rem_nxt   = '0;
                root_nxt  = '0;
                cnt_nxt   = '0;
                state_nxt = ST_SQRT;
              end
            end
            default: begin
              rem_nxt   = {{(SUB_W-TOP_W){1'b0}}, acc_r[P_W-1:TOP_LSB]};
              wk_nxt    = {acc_r[TOP_LSB-1:0], {SCALE_SH{1'b0}}, {(D_W-SUM_W){1'b0}}};
              root_nxt  = '0;
              state_nxt = ST_DCHK;
            end
          endcase
        end
      end
      ST_SQRT: begin
        rem_nxt  = sub_ge ? sub_d[SUB_W-1:0] : sub_x;
        root_nxt = {root_r[ROOT_W-2:0], sub_ge};
        wk_nxt   = wk_r << 2;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(ROOT_W - 1)) begin
          grp_nxt   = GRP_E;
          k_nxt     = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_DCHK: begin
        // quotient of 2^32 or more when (p << 9) >> 32 >= a
        if (sub_ge) begin
          tsat_nxt  = 1'b1;
          state_nxt = ST_ACC;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = sub_ge ? sub_d[SUB_W-1:0] : sub_x;
        root_nxt = {root_r[ROOT_W-2:0], sub_ge};
        wk_nxt   = wk_r << 1;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(SUM_W - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last_r) begin
          sum_nxt   = new_sum;
          clip_nxt  = new_clip;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_sum_nxt   = new_sum;
          out_sat_nxt   = new_clip;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          clip_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      sum_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      sum_r       <= sum_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ox_r   <= in_origin_x;
      oy_r   <= in_origin_y;
      oz_r   <= in_origin_z;
      dx_r   <= in_dir_x;
      dy_r   <= in_dir_y;
      dz_r   <= in_dir_z;
      den_r  <= in_density;
      last_r <= in_last_shape;
    end
    grp_r     <= grp_nxt;
    k_r       <= k_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    psh_r     <= psh_nxt;
    pneg_r    <= pneg_nxt;
    acc_r     <= acc_nxt;
    a_r       <= a_nxt;
    bm_r      <= bm_nxt;
    cm_r      <= cm_nxt;
    cneg_r    <= cneg_nxt;
    wk_r      <= wk_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    zero_r    <= zero_nxt;
    tsat_r    <= tsat_nxt;
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
  end

endmodule

// File: hdl/recs_checker.sv
// recs_checker: port-level assertions for ray_ellipsoid_chord_sum, and the
// bind that attaches them. Uses recs_pkg for field widths.

module recs_checker
  import recs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SUM_W-1:0]  out_line_integral,
  input logic              out_saturated
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_integral)
      && $stable(out_saturated))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a request was taken");

  // clipping always pins the sum at full scale
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_line_integral == '1)
    else $error("saturated flag without full-scale sum");

  // a result never appears in the cycle right after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too soon after a request");

endmodule

bind ray_ellipsoid_chord_sum recs_checker u_recs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_line_integral (out_line_integral),
  .out_saturated     (out_saturated)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for ray_ellipsoid_chord_sum with a built-in chord-sum predictor.
// Depends on recs_pkg and the ray_ellipsoid_chord_sum RTL.

module tb_top;
  import recs_pkg::*;

  localparam int Q1           = 1 << COORD_FRAC_BITS;
  localparam int CMAX         = 8388607;
  localparam int CMIN         = -8388608;
  localparam int RAND_PER_PH  = 400;
  localparam int HOLD_CYCLES  = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LIMIT        = 1000000;

  typedef enum logic [1:0] {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

  typedef struct {
    coord_t            origin_x, origin_y, origin_z;
    coord_t            dir_x, dir_y, dir_z;
    logic [DENS_W-1:0] density;
    logic              last_shape;
  } shape_t;

  typedef struct {
    logic [SUM_W-1:0] line_integral;
    logic             saturated;
  } pixel_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SUM_W-1:0] out_line_integral;
  logic out_saturated;
  logic in_taken = 1'b0;
  shape_t offer = '{default: '0};

  shape_t     shapes_q[$];
  pixel_sum_t pixel_sums_q[$];
  phase_t     phase = PH_FREE;
  phase_t     held_phase = PH_FREE;
  int         hold_left = 0;
  logic [SUM_W-1:0] acc_sum = '0;
  logic       acc_clip = 1'b0;
  int         err_cnt = 0;
  int         shapes_sent = 0;
  int         results_seen = 0;
  int         sat_seen = 0;
  int         cycle_cnt = 0;

  ray_ellipsoid_chord_sum i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_origin_x       (offer.origin_x),
    .in_origin_y       (offer.origin_y),
    .in_origin_z       (offer.origin_z),
    .in_dir_x          (offer.dir_x),
    .in_dir_y          (offer.dir_y),
    .in_dir_z          (offer.dir_z),
    .in_density        (offer.density),
    .in_last_shape     (offer.last_shape),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_integral (out_line_integral),
    .out_saturated     (out_saturated)
  );

  always #6 clk = ~clk;

  // 2*sqrt(b^2 - ac)/a * density in Q16.16, exact integer math
  function automatic logic [SUM_W-1:0] chord_term(input shape_t s, output logic clip);
    logic signed [127:0] ox, oy, oz, dx, dy, dz, a, b, c, d;
    logic [127:0] du, root, t, num, quo;
    clip = 1'b0;
    ox = s.origin_x; oy = s.origin_y; oz = s.origin_z;
    dx = s.dir_x;    dy = s.dir_y;    dz = s.dir_z;
    a = dx * dx + dy * dy + dz * dz;
    b = dx * ox + dy * oy + dz * oz;
    c = ox * ox + oy * oy + oz * oz - (128'sd1 <<< (2 * COORD_FRAC_BITS));
    if (a <= 0) return '0;
    d = b * b - a * c;
    if (d <= 0) return '0;
    du = d;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      t = root | (128'd1 << i);
      if (t * t <= du) root = t;
    end
    num = (root * s.density) << SCALE_SH;
    quo = num / 128'(a);
    if (quo > 128'h0FFFF_FFFF) begin
      clip = 1'b1;
      return '1;
    end
    return quo[SUM_W-1:0];
  endfunction

  function automatic void add_shape(input shape_t s);
    logic clip;
    logic [SUM_W-1:0] term;
    logic [SUM_W:0] sum;
    term = chord_term(s, clip);
    sum = {1'b0, acc_sum} + term;
    if (sum[SUM_W]) begin
      acc_sum = '1;
      clip = 1'b1;
    end else begin
      acc_sum = sum[SUM_W-1:0];
    end
    if (clip) acc_clip = 1'b1;
    if (s.last_shape) begin
      pixel_sums_q.push_back('{line_integral: acc_sum, saturated: acc_clip});
      acc_sum = '0;
      acc_clip = 1'b0;
    end
  endfunction

  function automatic coord_t span_coord(input int bits);
    logic signed [31:0] v;
    v = $signed($urandom) >>> (32 - bits);
    return coord_t'(v);
  endfunction

  task automatic push_shape(input int ox, oy, oz, dx, dy, dz, input int dens, input bit last);
    shape_t s;
    s.origin_x = coord_t'(ox); s.origin_y = coord_t'(oy); s.origin_z = coord_t'(oz);
    s.dir_x = coord_t'(dx);    s.dir_y = coord_t'(dy);    s.dir_z = coord_t'(dz);
    s.density = DENS_W'(dens);
    s.last_shape = last;
    shapes_q.push_back(s);
  endtask

  // one pixel: 1..6 shapes, mostly rays that can reach the unit sphere
  task automatic add_pixel(inout int count);
    int n, kind, e, t, r;
    shape_t s;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        s.origin_x = span_coord(18); s.origin_y = span_coord(18); s.origin_z = span_coord(18);
        e = $urandom_range(6, 24);
        s.dir_x = span_coord(e); s.dir_y = span_coord(e); s.dir_z = span_coord(e);
      end else if (kind < 65) begin
        e = $urandom_range(4, 20);
        t = $urandom_range(0, (8388608 - 131072) >> e);
        s.dir_x = span_coord(e + 1); s.dir_y = span_coord(e + 1); s.dir_z = span_coord(e + 1);
        s.origin_x = coord_t'(int'(span_coord(17)) - t * int'(s.dir_x));
        s.origin_y = coord_t'(int'(span_coord(17)) - t * int'(s.dir_y));
        s.origin_z = coord_t'(int'(span_coord(17)) - t * int'(s.dir_z));
      end else if (kind < 80) begin
        s.origin_x = coord_t'($urandom); s.origin_y = coord_t'($urandom);
        s.origin_z = coord_t'($urandom);
        s.dir_x = coord_t'($urandom); s.dir_y = coord_t'($urandom); s.dir_z = coord_t'($urandom);
      end else begin
        s.origin_x = span_coord($urandom_range(1, 24));
        s.origin_y = span_coord($urandom_range(1, 24));
        s.origin_z = span_coord($urandom_range(1, 24));
        s.dir_x = span_coord($urandom_range(1, 24));
        s.dir_y = span_coord($urandom_range(1, 24));
        s.dir_z = span_coord($urandom_range(1, 24));
      end
      r = $urandom_range(0, 9);
      s.density = (r == 0) ? '0 : (r == 1) ? '1 : DENS_W'($urandom);
      s.last_shape = (i == n - 1);
      shapes_q.push_back(s);
      count++;
    end
  endtask

  // sender: new request only once the previous one has been taken
  always @(negedge clk) begin : shape_driver
    int unsigned idle_pct;
    case (phase)
      PH_SEND_IDLE: idle_pct = 51;
      PH_BOTH:      idle_pct = 27;
      default:      idle_pct = 0;
    endcase
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (shapes_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        offer <= shapes_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off at the start of the stall phase
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      held_phase <= PH_FREE;
    end else begin
      held_phase <= phase;
      if (phase == PH_RECV_STALL && held_phase != PH_RECV_STALL) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin : result_sink
    int unsigned stall_pct;
    case (phase)
      PH_RECV_STALL: stall_pct = 51;
      PH_BOTH:       stall_pct = 27;
      default:       stall_pct = 0;
    endcase
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : monitor
    pixel_sum_t exp_sum;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        shapes_sent++;
        add_shape(offer);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_saturated) sat_seen++;
        if (pixel_sums_q.size() == 0) begin
          $error("unexpected result: line_integral %h saturated %b",
                 out_line_integral, out_saturated);
          err_cnt++;
        end else begin
          exp_sum = pixel_sums_q.pop_front();
          if (out_line_integral !== exp_sum.line_integral) begin
            $error("line_integral: expected %h, got %h",
                   exp_sum.line_integral, out_line_integral);
            err_cnt++;
          end
          if (out_saturated !== exp_sum.saturated) begin
            $error("saturated: expected %b, got %b", exp_sum.saturated, out_saturated);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int added;
    // zero direction, miss, tangent
    push_shape(0, 0, 0, 0, 0, 0, 16'h0100, 1);
    push_shape(2 * Q1, 0, 0, 0, Q1, 0, 16'h0100, 1);
    push_shape(Q1, 0, 0, 0, Q1, 0, 16'h0100, 1);
    // two chords of length 2 from both sides
    push_shape(0, 0, -2 * Q1, 0, 0, Q1, 16'h0100, 0);
    push_shape(0, 0, 2 * Q1, 0, 0, -Q1, 16'h0100, 1);
    // zero and full density
    push_shape(0, 0, 0, Q1, 0, 0, 0, 1);
    push_shape(0, 0, 0, 0, Q1, 0, 16'hFFFF, 1);
    // term clips
    push_shape(0, 0, 0, 1, 0, 0, 16'hFFFF, 1);
    // sum overflow over three big terms
    push_shape(0, 0, 0, 1024, 0, 0, 16'hFFFF, 0);
    push_shape(0, 0, 0, 0, 1024, 0, 16'hFFFF, 0);
    push_shape(0, 0, 0, 0, 0, -1024, 16'hFFFF, 1);
    // field extremes
    push_shape(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 16'hFFFF, 1);
    push_shape(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 1);
    push_shape(0, 0, 0, CMIN, CMAX, CMIN, 16'hFFFF, 1);
    push_shape(CMAX, 0, 0, -Q1, 0, 0, 16'hFFFF, 1);
    // clip flag carried through a later miss
    push_shape(0, 0, 0, -1, 0, 0, 16'hFFFF, 0);
    push_shape(2 * Q1, 2 * Q1, 0, Q1, 0, 0, 16'hFFFF, 1);
    added = 0;
    while (added < RAND_PER_PH) add_pixel(added);
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (shapes_q.size() != 0) @(posedge clk);
    for (int p = 1; p < 4; p++) begin
      phase = phase_t'(p);
      added = 0;
      while (added < RAND_PER_PH) add_pixel(added);
      while (shapes_q.size() != 0) @(posedge clk);
    end
    while (shapes_q.size() != 0 || in_valid || pixel_sums_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d shapes, checked %0d pixel sums (%0d saturated)",
             shapes_sent, results_seen, sat_seen);
    $display("Phases: free flow, sender gaps, receiver stalls with long hold-off, both");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
